>>> rtl/core/hsr_pkg.sv
// Shared types, codes and widths for the handle stack with release.
package hsr_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned HANDLE_W  = 32;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned STATUS_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_PEEK    = 3'd2,
    CMD_TRUNC   = 3'd3,
    CMD_REPLACE = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic latch;    // capture the accepted word
    logic imm;      // load a result that needs no memory read
    logic issue;    // start the first memory read
    logic rd_load;  // load a result built from read data
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_read;
    logic rd_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/core/hsr_if.sv
// Request and response channel interfaces.
interface hsr_req_if import hsr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [HANDLE_W-1:0] handle;
  logic [SLOT_W-1:0]   slot;

  modport source (output valid, cmd, handle, slot, input ready);
  modport sink   (input valid, cmd, handle, slot, output ready);
endinterface

interface hsr_rsp_if import hsr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] out_handle;
  logic [SLOT_W-1:0]   out_slot;
  logic                released;
  logic                last;

  modport source (output valid, status, out_handle, out_slot, released, last, input ready);
  modport sink   (input valid, status, out_handle, out_slot, released, last, output ready);
endinterface

>>> rtl/core/handle_stack_with_release_unit.sv
// LIFO stack of 32-bit object handles, DEPTH entries, with release reporting.
// A request word is taken only when the unit is idle. Push and any command
// answered without reading the stack (full, empty, bad index, unknown code,
// truncate that keeps everything) load their result without a memory read;
// pop, peek and replace use the registered read of the entry memory; a
// truncate that discards n entries gives n response words, one per cycle
// while the response is taken, lowest slot first, the final one marked last.
// The response register lets the next request in while a result waits; a
// stalled response holds the unit. Entry memory needs no clearing after reset.
module handle_stack_with_release_unit import hsr_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hsr_req_if.sink   req_i,
  hsr_rsp_if.source rsp_o
);

  ctrl_cmd_t ctl;
  dp_stat_t  stat;
  logic      in_ready;

  assign req_i.ready = in_ready;

  hsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  hsr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (req_i.cmd),
    .handle_i (req_i.handle),
    .slot_i   (req_i.slot),
    .ctl_i    (ctl),
    .stat_o   (stat),
    .rsp_o    (rsp_o)
  );

endmodule

>>> rtl/core/hsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hsr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/hsr_ctrl.sv
// Sequencer for the handle stack: accept, execute, read-and-emit loop.
module hsr_ctrl import hsr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t ctl_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.need_read) begin
          ctl_o.issue = 1'b1;
          state_d     = S_READ;
        end else if (stat_i.out_free) begin
          ctl_o.imm = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_READ: begin
        // truncate stays here, one released word per cycle while the output is free
        if (stat_i.out_free) begin
          ctl_o.rd_load = 1'b1;
          if (stat_i.rd_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/hsr_dp.sv
// Datapath: entry memory, count, read pointer and output register.
module hsr_dp import hsr_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  ctrl_cmd_t           ctl_i,
  output dp_stat_t            stat_o,
  hsr_rsp_if.source           rsp_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = ((CW > SLOT_W) ? CW : SLOT_W) + 1;

  logic [CMD_W-1:0]    cmd_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       ptr_q;

  logic [CMPW-1:0] cnt_c, slot_c, ptr_c;
  logic is_push, is_pop, is_peek, is_trunc, is_repl;
  logic full, empty, oor, tnone, differ, rd_last, out_free, load;

  logic                re, we;
  logic [AW-1:0]       raddr, waddr;
  logic [HANDLE_W-1:0] rdata;

  logic [STATUS_W-1:0] res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic [SLOT_W-1:0]   res_slot;
  logic                res_rel, res_last;

  logic                valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [HANDLE_W-1:0] ohandle_q;
  logic [SLOT_W-1:0]   oslot_q;
  logic                rel_q, last_q;

  assign cnt_c  = CMPW'(count_q);
  assign slot_c = CMPW'(slot_q);
  assign ptr_c  = CMPW'(ptr_q);

  assign is_push  = cmd_q == CMD_PUSH;
  assign is_pop   = cmd_q == CMD_POP;
  assign is_peek  = cmd_q == CMD_PEEK;
  assign is_trunc = cmd_q == CMD_TRUNC;
  assign is_repl  = cmd_q == CMD_REPLACE;

  assign full   = count_q == CW'(DEPTH);
  assign empty  = count_q == '0;
  assign oor    = slot_c >= cnt_c;
  assign tnone  = (slot_c + CMPW'(1)) == cnt_c;
  assign differ = rdata != handle_q;

  assign rd_last  = !is_trunc || ((ptr_c + CMPW'(1)) == cnt_c);
  assign out_free = !valid_q || rsp_o.ready;
  assign load     = ctl_i.imm || ctl_i.rd_load;

  assign stat_o.need_read = (is_pop && !empty) || (is_peek && !oor) ||
                            (is_trunc && !oor && !tnone) || (is_repl && !oor);
  assign stat_o.rd_last   = rd_last;
  assign stat_o.out_free  = out_free;

  // read address: first read picks by command, truncate then walks upward
  always_comb begin
    raddr = AW'(ptr_c + CMPW'(1));
    if (ctl_i.issue) begin
      priority if (is_pop) begin
        raddr = AW'(cnt_c - CMPW'(1));
      end else if (is_peek) begin
        raddr = AW'(cnt_c - CMPW'(1) - slot_c);
      end else if (is_trunc) begin
        raddr = AW'(slot_c + CMPW'(1));
      end else begin
        raddr = AW'(slot_c);
      end
    end
  end

  assign re    = ctl_i.issue || (ctl_i.rd_load && is_trunc && !rd_last);
  assign we    = (ctl_i.imm && is_push && !full) || (ctl_i.rd_load && is_repl && differ);
  assign waddr = is_push ? AW'(count_q) : ptr_q;

  hsr_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (handle_q),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    count_d = count_q;
    if (ctl_i.imm && is_push && !full) begin
      count_d = count_q + CW'(1);
    end else if (ctl_i.issue && is_pop) begin
      count_d = count_q - CW'(1);
    end else if (ctl_i.rd_load && is_trunc && rd_last) begin
      count_d = CW'(slot_c + CMPW'(1));
    end
  end

  // result word
  always_comb begin
    res_status = ST_BAD;
    res_handle = '0;
    res_slot   = '0;
    res_rel    = 1'b0;
    res_last   = 1'b1;
    if (ctl_i.rd_load) begin
      res_status = ST_OK;
      res_handle = (is_repl && !differ) ? '0 : rdata;
      res_slot   = SLOT_W'(ptr_q);
      res_rel    = is_trunc || (is_repl && differ);
      res_last   = rd_last;
    end else begin
      unique case (cmd_q)
        CMD_PUSH: begin
          res_status = full ? ST_FULL : ST_OK;
          res_slot   = full ? '0 : SLOT_W'(count_q);
        end
        CMD_POP, CMD_PEEK: begin
          res_status = ST_EMPTY;
        end
        CMD_TRUNC: begin
          // keeping everything: a plain ok with the kept slot
          if (tnone) begin
            res_status = ST_OK;
            res_slot   = slot_q;
          end
        end
        default: begin
          res_status = ST_BAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q    <= cmd_i;
      handle_q <= handle_i;
      slot_q   <= slot_i;
    end
    if (re) begin
      ptr_q <= raddr;
    end
    if (load) begin
      status_q  <= res_status;
      ohandle_q <= res_handle;
      oslot_q   <= res_slot;
      rel_q     <= res_rel;
      last_q    <= res_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid      = valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.out_handle = ohandle_q;
  assign rsp_o.out_slot   = oslot_q;
  assign rsp_o.released   = rel_q;
  assign rsp_o.last       = last_q;

endmodule
